// ===== hdl/page_replacement_lru_lfu_unit_assert.svh =====
// Assertion macros for the page replacement unit.
`ifndef PAGE_REPLACEMENT_LRU_LFU_UNIT_ASSERT_SVH
`define PAGE_REPLACEMENT_LRU_LFU_UNIT_ASSERT_SVH

// Property must hold at every clock edge out of reset.
`define PRLU_ASSERT_NOW(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PRLU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/prlu_pkg.sv =====
// Shared types and constants of the page replacement unit.
package prlu_pkg;

  localparam int PAGE_IN_W  = 6;
  localparam int TOTAL_W    = 16;
  localparam int FRAMES_W   = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int MIN_FRAMES = 2;
  localparam int MOD_STEPS  = 8;

  localparam logic [CFG_IDX_W-1:0] REG_POLICY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAMES = 1'b1;

  localparam logic POLICY_LRU = 1'b0;
  localparam logic POLICY_LFU = 1'b1;

  localparam logic [FRAMES_W-1:0] FRAMES_RESET = 5'd4;
  localparam logic [TOTAL_W-1:0]  TOTAL_MAX    = 16'hFFFF;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic take;
    logic upd;
  } cell_ctl_t;

endpackage

// ===== hdl/prlu_cell.sv =====
// One frame slot of the resident list, with its share of the minimum-count search.
module prlu_cell #(
  parameter int PAGE_W  = 6,
  parameter int COUNT_W = 16,
  parameter int POS_W   = 4,
  parameter int IDX     = 0
) (
  input  logic                 clk,
  input  prlu_pkg::cell_ctl_t  ctl,
  input  logic                 live,
  input  logic [PAGE_W-1:0]    key_page,
  input  logic [PAGE_W-1:0]    prev_page,
  input  logic [COUNT_W-1:0]   prev_count,
  input  logic [COUNT_W-1:0]   new_count,
  input  logic                 min_in_found,
  input  logic [COUNT_W-1:0]   min_in_count,
  input  logic [POS_W-1:0]     min_in_pos,
  output logic [PAGE_W-1:0]    page,
  output logic [COUNT_W-1:0]   count,
  output logic                 match,
  output logic                 min_out_found,
  output logic [COUNT_W-1:0]   min_out_count,
  output logic [POS_W-1:0]     min_out_pos
);
  import prlu_pkg::*;

  logic better;

  assign match  = live && (page == key_page);
  // strict compare keeps the entry nearest the front on a tie
  assign better = live && (!min_in_found || (count < min_in_count));

  always_ff @(posedge clk) begin
    if (ctl.take) begin
      page  <= prev_page;
      count <= prev_count;
    end else if (ctl.upd && match) begin
      count <= new_count;
    end
  end

  always_ff @(posedge clk) begin
    if (better) begin
      min_out_found <= 1'b1;
      min_out_count <= count;
      min_out_pos   <= POS_W'(IDX);
    end else begin
      min_out_found <= min_in_found;
      min_out_count <= min_in_count;
      min_out_pos   <= min_in_pos;
    end
  end

endmodule

// ===== hdl/prlu_count_ram.sv =====
// Access count memory, one write port and one registered read port.
module prlu_count_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  import prlu_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/page_replacement_lru_lfu_unit.sv =====
// Page replacement unit (LRU / LFU) top level.
// After reset the unit clears its access count memory, one entry a cycle, and
// holds page_stall high while it clears; configuration writes are taken at any
// time. A request that hits, or that faults in LRU mode or with a free frame,
// passes through a read state, which reads the page's count from memory, and a
// commit state, and the next request is taken in the commit state. A fault in
// LFU mode with every frame full passes through a scan state between the two,
// while the minimum-count token ripples one cell a cycle down the row of frame cells.
// A result waits in the output register until taken; while it waits the next
// request may already be read, but it does not commit.
`include "page_replacement_lru_lfu_unit_assert.svh"

module page_replacement_lru_lfu_unit #(
  parameter int VIRTUAL_PAGES = 64,
  parameter int MAX_FRAMES    = 16,
  parameter int COUNT_BITS    = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              page_valid,
  output logic                              page_stall,
  input  logic [prlu_pkg::PAGE_IN_W-1:0]    page_number,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic                              hit,
  output logic                              evicted_valid,
  output logic [prlu_pkg::PAGE_IN_W-1:0]    evicted_page,
  output logic [prlu_pkg::TOTAL_W-1:0]      hit_total,
  output logic [prlu_pkg::TOTAL_W-1:0]      fault_total,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [prlu_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [prlu_pkg::FRAMES_W-1:0]     cfg_data
);
  import prlu_pkg::*;

  localparam int PAGE_W  = $clog2(VIRTUAL_PAGES);
  localparam int POS_W   = $clog2(MAX_FRAMES);
  localparam int OCC_W   = $clog2(MAX_FRAMES + 1);
  localparam int WIDE_W  = PAGE_IN_W + 1;
  localparam logic [PAGE_W-1:0] CLR_LAST  = PAGE_W'(VIRTUAL_PAGES - 1);
  localparam logic [POS_W-1:0]  SCAN_LAST = POS_W'(MAX_FRAMES - 1);

  state_t state, state_next;

  logic                 policy_mode;
  logic [FRAMES_W-1:0]  frames_in_use;
  logic [OCC_W-1:0]     occ;
  logic [OCC_W-1:0]     cap;
  logic [PAGE_W-1:0]    clr_addr;
  logic [POS_W-1:0]     scan_cnt;
  logic [PAGE_W-1:0]    page_r;
  logic [PAGE_W-1:0]    page_red;
  logic [WIDE_W-1:0]    page_wide;
  logic [COUNT_BITS-1:0] cnt_rd;
  logic [COUNT_BITS-1:0] cnt_new;
  logic [COUNT_BITS-1:0] cnt_new_r;
  logic                 hit_r;
  logic                 evict_r;
  logic [POS_W-1:0]     pos_r;
  logic [POS_W-1:0]     hit_pos;
  logic                 hit_c;
  logic                 full_c;
  logic [TOTAL_W-1:0]   hits_seen;
  logic [TOTAL_W-1:0]   faults_seen;

  logic                 accept;
  logic                 out_free;
  logic                 commit;
  logic                 ram_wr_en;
  logic [PAGE_W-1:0]    ram_wr_addr;
  logic [COUNT_BITS-1:0] ram_wr_data;

  logic [PAGE_W-1:0]     cell_page   [MAX_FRAMES];
  logic [COUNT_BITS-1:0] cell_count  [MAX_FRAMES];
  logic [MAX_FRAMES-1:0] cell_match;
  logic [MAX_FRAMES-1:0] cell_live;
  logic [MAX_FRAMES-1:0] min_found;
  logic [COUNT_BITS-1:0] min_count   [MAX_FRAMES];
  logic [POS_W-1:0]      min_pos     [MAX_FRAMES];
  cell_ctl_t             cell_ctl    [MAX_FRAMES];

  assign cfg_ready = 1'b1;
  assign out_free  = !result_valid || !result_stall;
  assign accept    = page_valid && !page_stall;

  // reduce the page number into the virtual page range
  always_comb begin
    page_wide = WIDE_W'(page_number);
    for (int k = 0; k < MOD_STEPS; k++) begin
      if (int'(page_wide) >= VIRTUAL_PAGES) begin
        page_wide = page_wide - WIDE_W'(VIRTUAL_PAGES);
      end
    end
    page_red = PAGE_W'(page_wide);
  end

  always_comb begin
    cap = OCC_W'(MAX_FRAMES);
    if (int'(frames_in_use) < MIN_FRAMES) begin
      cap = OCC_W'(MIN_FRAMES);
    end else if (int'(frames_in_use) < MAX_FRAMES) begin
      cap = OCC_W'(frames_in_use);
    end
  end

  assign cnt_new = (cnt_rd == {COUNT_BITS{1'b1}}) ? cnt_rd : cnt_rd + 1'b1;
  assign hit_c   = |cell_match;
  assign full_c  = occ >= cap;

  always_comb begin
    hit_pos = '0;
    for (int i = 0; i < MAX_FRAMES; i++) begin
      cell_live[i] = OCC_W'(i) < occ;
      if (cell_match[i]) begin
        hit_pos = hit_pos | POS_W'(i);
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_addr == CLR_LAST) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) state_next = ST_READ;
      end
      ST_READ: begin
        if (!hit_c && full_c && policy_mode == POLICY_LFU) state_next = ST_SCAN;
        else state_next = ST_COMMIT;
      end
      ST_SCAN: begin
        if (scan_cnt == SCAN_LAST) state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (accept) state_next = ST_READ;
        else if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    page_stall  = 1'b1;
    commit      = 1'b0;
    ram_wr_en   = 1'b0;
    ram_wr_addr = page_r;
    ram_wr_data = cnt_new;
    unique case (state)
      ST_CLEAR: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = clr_addr;
        ram_wr_data = '0;
      end
      ST_IDLE: begin
        page_stall = 1'b0;
      end
      ST_READ: begin
        ram_wr_en = 1'b1;
      end
      ST_SCAN: begin
      end
      ST_COMMIT: begin
        commit     = out_free;
        page_stall = !out_free;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < MAX_FRAMES; i++) begin
      cell_ctl[i].take = commit && !(hit_r && policy_mode == POLICY_LFU)
                         && (POS_W'(i) <= pos_r);
      cell_ctl[i].upd  = commit && hit_r && policy_mode == POLICY_LFU;
    end
  end

  prlu_count_ram #(
    .DEPTH (VIRTUAL_PAGES),
    .WIDTH (COUNT_BITS)
  ) u_count_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (accept),
    .rd_addr (page_red),
    .rd_data (cnt_rd)
  );

  for (genvar g = 0; g < MAX_FRAMES; g++) begin : g_cell
    logic [PAGE_W-1:0]     prev_page;
    logic [COUNT_BITS-1:0] prev_count;
    logic                  prev_found;
    logic [COUNT_BITS-1:0] prev_min;
    logic [POS_W-1:0]      prev_pos;

    if (g == 0) begin : g_front
      assign prev_page  = page_r;
      assign prev_count = cnt_new_r;
      assign prev_found = 1'b0;
      assign prev_min   = '0;
      assign prev_pos   = '0;
    end else begin : g_rest
      assign prev_page  = cell_page[g-1];
      assign prev_count = cell_count[g-1];
      assign prev_found = min_found[g-1];
      assign prev_min   = min_count[g-1];
      assign prev_pos   = min_pos[g-1];
    end

    prlu_cell #(
      .PAGE_W  (PAGE_W),
      .COUNT_W (COUNT_BITS),
      .POS_W   (POS_W),
      .IDX     (g)
    ) u_cell (
      .clk           (clk),
      .ctl           (cell_ctl[g]),
      .live          (cell_live[g]),
      .key_page      (page_r),
      .prev_page     (prev_page),
      .prev_count    (prev_count),
      .new_count     (cnt_new_r),
      .min_in_found  (prev_found),
      .min_in_count  (prev_min),
      .min_in_pos    (prev_pos),
      .page          (cell_page[g]),
      .count         (cell_count[g]),
      .match         (cell_match[g]),
      .min_out_found (min_found[g]),
      .min_out_count (min_count[g]),
      .min_out_pos   (min_pos[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      clr_addr      <= '0;
      policy_mode   <= POLICY_LRU;
      frames_in_use <= FRAMES_RESET;
      occ           <= '0;
      hits_seen     <= '0;
      faults_seen   <= '0;
      result_valid  <= 1'b0;
      scan_cnt      <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_POLICY: policy_mode   <= cfg_data[0];
          REG_FRAMES: frames_in_use <= cfg_data;
          default: begin
          end
        endcase
      end
      if (state == ST_READ) begin
        scan_cnt <= '0;
      end else if (state == ST_SCAN) begin
        scan_cnt <= scan_cnt + 1'b1;
      end
      if (commit) begin
        result_valid <= 1'b1;
        if (hit_r) begin
          if (hits_seen != TOTAL_MAX) hits_seen <= hits_seen + 1'b1;
        end else begin
          if (faults_seen != TOTAL_MAX) faults_seen <= faults_seen + 1'b1;
          if (!evict_r) occ <= occ + 1'b1;
        end
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      page_r <= page_red;
    end
    if (state == ST_READ) begin
      hit_r     <= hit_c;
      evict_r   <= !hit_c && full_c;
      cnt_new_r <= cnt_new;
      if (hit_c) pos_r <= hit_pos;
      else if (full_c) pos_r <= POS_W'(occ - 1'b1);
      else pos_r <= POS_W'(occ);
    end else if (state == ST_SCAN && scan_cnt == SCAN_LAST) begin
      pos_r <= min_pos[MAX_FRAMES-1];
    end
    if (commit) begin
      hit           <= hit_r;
      evicted_valid <= evict_r;
      evicted_page  <= evict_r ? PAGE_IN_W'(cell_page[pos_r]) : '0;
      hit_total     <= (hit_r && hits_seen != TOTAL_MAX) ? hits_seen + 1'b1 : hits_seen;
      fault_total   <= (!hit_r && faults_seen != TOTAL_MAX) ?
                       faults_seen + 1'b1 : faults_seen;
    end
  end

  `PRLU_ASSERT_NOW(a_occ_bound, occ <= OCC_W'(MAX_FRAMES), "occupancy above frame count")
  `PRLU_ASSERT_NOW(a_scan_lfu, (state == ST_SCAN) |-> (policy_mode == POLICY_LFU && !hit_r && evict_r), "search without LFU eviction")
  `PRLU_ASSERT_NEXT(a_commit_result, commit, result_valid, "commit without result")
  `PRLU_ASSERT_NOW(a_clear_stall, (state == ST_CLEAR) |-> page_stall, "request taken during clear")

endmodule

// ===== tb/page_replacement_checker.sv =====
// Checker for the page replacement unit: access predictor and result scoreboard.
`timescale 1ns / 1ps

module page_replacement_checker #(
  parameter int VIRTUAL_PAGES = 64,
  parameter int MAX_FRAMES    = 16,
  parameter int COUNT_BITS    = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           page_valid,
  input  logic                           page_stall,
  input  logic [prlu_pkg::PAGE_IN_W-1:0] page_number,
  input  logic                           result_valid,
  input  logic                           result_stall,
  input  logic                           hit,
  input  logic                           evicted_valid,
  input  logic [prlu_pkg::PAGE_IN_W-1:0] evicted_page,
  input  logic [prlu_pkg::TOTAL_W-1:0]   hit_total,
  input  logic [prlu_pkg::TOTAL_W-1:0]   fault_total,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [prlu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [prlu_pkg::FRAMES_W-1:0]  cfg_data,
  output int                             fail_count,
  output int                             outstanding
);
  import prlu_pkg::*;

  typedef struct packed {
    logic                 hit;
    logic                 evicted_valid;
    logic [PAGE_IN_W-1:0] evicted_page;
    logic [TOTAL_W-1:0]   hit_total;
    logic [TOTAL_W-1:0]   fault_total;
  } access_result_t;

  localparam logic [COUNT_BITS-1:0] COUNT_SAT = '1;

  // Model copy of the unit's state and registers
  logic                  policy;
  logic [FRAMES_W-1:0]   frames_cfg;
  logic [PAGE_IN_W-1:0]  resident_order [MAX_FRAMES];
  int                    occupancy;
  bit                    present [VIRTUAL_PAGES];
  logic [COUNT_BITS-1:0] page_uses [VIRTUAL_PAGES];
  logic [TOTAL_W-1:0]    hits_so_far;
  logic [TOTAL_W-1:0]    faults_so_far;

  access_result_t expected_results [$];
  int             results_checked;

  function automatic access_result_t predict_access(input logic [PAGE_IN_W-1:0] page);
    access_result_t        r;
    int                    pos;
    int                    victim;
    int                    cap;
    logic [COUNT_BITS-1:0] lowest;
    r = '0;
    r.hit = present[page];
    if (page_uses[page] != COUNT_SAT) page_uses[page]++;
    if (r.hit) begin
      if (policy == POLICY_LRU) begin
        pos = 0;
        while (pos < occupancy && resident_order[pos] != page) pos++;
        // move the page to the front
        for (int i = pos; i > 0; i--) resident_order[i] = resident_order[i-1];
        resident_order[0] = page;
      end
      if (hits_so_far != TOTAL_MAX) hits_so_far++;
    end else begin
      cap = frames_cfg;
      if (cap < MIN_FRAMES) cap = MIN_FRAMES;
      if (cap > MAX_FRAMES) cap = MAX_FRAMES;
      if (occupancy >= cap && occupancy > 0) begin
        if (policy == POLICY_LRU) begin
          victim = occupancy - 1;
        end else begin
          // smallest count wins, ties go to the entry nearest the front
          victim = 0;
          lowest = page_uses[resident_order[0]];
          for (int i = 1; i < occupancy; i++) begin
            if (page_uses[resident_order[i]] < lowest) begin
              lowest = page_uses[resident_order[i]];
              victim = i;
            end
          end
        end
        r.evicted_valid = 1'b1;
        r.evicted_page  = resident_order[victim];
        present[resident_order[victim]] = 1'b0;
        for (int i = victim; i < occupancy - 1; i++) resident_order[i] = resident_order[i+1];
        occupancy--;
      end
      if (occupancy < MAX_FRAMES) begin
        for (int i = occupancy; i > 0; i--) resident_order[i] = resident_order[i-1];
        resident_order[0] = page;
        occupancy++;
      end
      present[page] = 1'b1;
      if (faults_so_far != TOTAL_MAX) faults_so_far++;
    end
    r.hit_total   = hits_so_far;
    r.fault_total = faults_so_far;
    return r;
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("[%0t] result %0d: %s is %0d, expected %0d",
             $realtime, results_checked, field, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    access_result_t want;
    if (rst) begin
      policy        = POLICY_LRU;
      frames_cfg    = FRAMES_RESET;
      occupancy     = 0;
      hits_so_far   = '0;
      faults_so_far = '0;
      for (int i = 0; i < VIRTUAL_PAGES; i++) begin
        present[i]   = 1'b0;
        page_uses[i] = '0;
      end
      for (int i = 0; i < MAX_FRAMES; i++) resident_order[i] = '0;
      expected_results.delete();
      results_checked = 0;
      fail_count      = 0;
      outstanding    <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_POLICY: policy = cfg_data[0];
          REG_FRAMES: frames_cfg = cfg_data;
          default: ;
        endcase
      end
      // retire before predicting so a stray result cannot match this cycle's request
      if (result_valid && !result_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result_valid", 1, 0);
        end else begin
          want = expected_results.pop_front();
          if (hit !== want.hit) report_mismatch("hit", hit, want.hit);
          if (evicted_valid !== want.evicted_valid)
            report_mismatch("evicted_valid", evicted_valid, want.evicted_valid);
          if (evicted_page !== want.evicted_page)
            report_mismatch("evicted_page", evicted_page, want.evicted_page);
          if (hit_total !== want.hit_total)
            report_mismatch("hit_total", hit_total, want.hit_total);
          if (fault_total !== want.fault_total)
            report_mismatch("fault_total", fault_total, want.fault_total);
        end
        results_checked++;
      end
      if (page_valid && !page_stall)
        expected_results.insert(expected_results.size(), predict_access(page_number));
      outstanding <= expected_results.size();
    end
  end

endmodule

// ===== tb/testbench.sv =====
// Top of the page replacement testbench: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
  import prlu_pkg::*;

  localparam int VIRTUAL_PAGES = 64;
  localparam int MAX_FRAMES    = 16;
  localparam int COUNT_BITS    = 16;
  localparam int PHASES        = 12;
  localparam int PHASE_ITEMS   = 80;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 page_valid = 1'b0;
  logic                 page_stall;
  logic [PAGE_IN_W-1:0] page_number = '0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  logic                 hit;
  logic                 evicted_valid;
  logic [PAGE_IN_W-1:0] evicted_page;
  logic [TOTAL_W-1:0]   hit_total;
  logic [TOTAL_W-1:0]   fault_total;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [FRAMES_W-1:0]  cfg_data = '0;

  int fail_count;
  int outstanding;

  page_replacement_lru_lfu_unit #(
    .VIRTUAL_PAGES(VIRTUAL_PAGES),
    .MAX_FRAMES   (MAX_FRAMES),
    .COUNT_BITS   (COUNT_BITS)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .page_valid   (page_valid),
    .page_stall   (page_stall),
    .page_number  (page_number),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .hit          (hit),
    .evicted_valid(evicted_valid),
    .evicted_page (evicted_page),
    .hit_total    (hit_total),
    .fault_total  (fault_total),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  page_replacement_checker #(
    .VIRTUAL_PAGES(VIRTUAL_PAGES),
    .MAX_FRAMES   (MAX_FRAMES),
    .COUNT_BITS   (COUNT_BITS)
  ) u_checker (
    .clk          (clk),
    .rst          (rst),
    .page_valid   (page_valid),
    .page_stall   (page_stall),
    .page_number  (page_number),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .hit          (hit),
    .evicted_valid(evicted_valid),
    .evicted_page (evicted_page),
    .hit_total    (hit_total),
    .fault_total  (fault_total),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .outstanding  (outstanding)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Result stall: cycle through quiet, light, heavy and periodic stretches
  logic [7:0] stall_phase = '0;
  always @(posedge clk) begin
    if (rst) begin
      stall_phase  <= '0;
      result_stall <= 1'b0;
    end else begin
      stall_phase <= stall_phase + 8'd1;
      case (stall_phase[7:6])
        2'd0: result_stall <= 1'b0;
        2'd1: result_stall <= ($urandom_range(0, 1) == 1);
        2'd2: result_stall <= ($urandom_range(0, 4) != 0);
        default: result_stall <= stall_phase[2];
      endcase
    end
  end

  int burst_left;
  bit no_gaps;

  // Present one request and hold it until it is taken
  task automatic send_access(input logic [PAGE_IN_W-1:0] pg);
    page_valid  <= 1'b1;
    page_number <= pg;
    do @(posedge clk); while (page_stall);
    if (!no_gaps) begin
      if (burst_left == 0) begin
        page_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst_left = $urandom_range(1, 20);
      end else begin
        burst_left--;
      end
    end
  endtask

  // Drop valid and wait until every result has come back
  task automatic drain_results();
    page_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [FRAMES_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic apply_setting(input logic pol, input logic [FRAMES_W-1:0] frames);
    cfg_write(REG_FRAMES, frames);
    cfg_write(REG_POLICY, {4'($urandom_range(0, 15)), pol});
    cfg_valid <= 1'b0;
  endtask

  logic [PAGE_IN_W-1:0] lru_warmup [12] = '{0, 63, 1, 2, 0, 5, 63, 42, 21, 5, 5, 7};
  logic [PAGE_IN_W-1:0] lfu_warmup [10] = '{9, 9, 9, 10, 11, 12, 13, 9, 14, 10};
  logic                 plan_policy [PHASES] = '{POLICY_LRU, POLICY_LFU, POLICY_LFU,
                                                 POLICY_LRU, POLICY_LFU, POLICY_LRU,
                                                 POLICY_LFU, POLICY_LRU, POLICY_LFU,
                                                 POLICY_LRU, POLICY_LFU, POLICY_LRU};
  logic [FRAMES_W-1:0]  plan_frames [PHASES] = '{16, 16, 2, 0, 1, 31, 17, 8, 5, 2, 12, 3};

  initial begin
    int ws_base;
    int ws_size;
    int cap;
    int offset;
    burst_left = 0;
    no_gaps    = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset setting first, then the same frames under LFU
    foreach (lru_warmup[i]) send_access(lru_warmup[i]);
    drain_results();
    apply_setting(POLICY_LFU, FRAMES_RESET);
    foreach (lfu_warmup[i]) send_access(lfu_warmup[i]);
    drain_results();

    for (int ph = 0; ph < PHASES; ph++) begin
      apply_setting(plan_policy[ph], plan_frames[ph]);
      cap = plan_frames[ph];
      if (cap < MIN_FRAMES) cap = MIN_FRAMES;
      if (cap > MAX_FRAMES) cap = MAX_FRAMES;
      no_gaps    = (ph % 3 == 0);
      burst_left = $urandom_range(1, 20);
      ws_base    = $urandom_range(0, VIRTUAL_PAGES - 1);
      ws_size    = cap + $urandom_range(0, 3);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // mostly a skewed working set slightly larger than the frames, some noise
        if ($urandom_range(0, 9) < 8) begin
          offset = $urandom_range(0, $urandom_range(0, ws_size - 1));
          send_access(PAGE_IN_W'((ws_base + offset) % VIRTUAL_PAGES));
        end else begin
          send_access(PAGE_IN_W'($urandom_range(0, VIRTUAL_PAGES - 1)));
        end
      end
      drain_results();
    end

    repeat (MAX_FRAMES + 4) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", outstanding);
    $display("FAILED: results differ");
    $finish;
  end

endmodule
